[design/double_ended_queue_core_defines.svh]
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Concurrent check macros shared by the queue RTL; they compile away when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that is muted while reset is applied.
`define DEQ_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that also holds during reset.
`define DEQ_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEQ_CHECK(lbl, prop, msg)
`define DEQ_CHECK_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, action codes, status codes and the cell control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

	// Number of storage cells in the chain.
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	typedef logic signed [31:0] word_t;

	// Action codes carried on the action port; code 7 behaves as a peek.
	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_CLEAR      = 3'd4,
		ACT_REVERSE    = 3'd5,
		ACT_PEEK       = 3'd6
	} action_t;

	// Status codes reported with each result word.
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL = 2'd2;

	// Control broadcast along the chain of cells.
	typedef struct packed {
		logic shift_up;    // every cell takes its lower neighbour (insert at start)
		logic shift_down;  // every cell takes its upper neighbour (remove at start)
	} cell_ctl_t;

endpackage

[design/deq_cell.sv]
// ----------------------------------------------------------------------------
// Double-ended queue storage cell
// One slot of the chain: shifts with its neighbours or takes a new word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_cell
	import deq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      append,
	input  word_t     lower,
	input  word_t     upper,
	input  word_t     value,
	output word_t     q
);

	word_t data_q;

	// Slot register: shift moves take priority, an append writes the new word.
	always_ff @(posedge clk) begin
		if (ctl.shift_up) begin
			data_q <= lower;
		end else if (ctl.shift_down) begin
			data_q <= upper;
		end else if (append) begin
			data_q <= value;
		end
	end

	assign q = data_q;

endmodule

[design/double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// Double-ended queue core
// Signed 32-bit deque held in a chain of shifting storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (action, value) is taken at a rising edge where start is
//   high and busy is low. busy stays low, so one command can be issued in
//   every cycle.
//   Each command gives one result word in the next cycle: done is high for
//   exactly one cycle while front_value, back_value, count, is_empty and
//   status are valid. Throughput is one command per cycle.
//   The cells hold the values in logical order from the physical start; a
//   push or pop at the start shifts the whole chain by one cell in that
//   cycle, a push at the end writes the cell at the fill level, and a pop at
//   the end only lowers the fill level. Reverse toggles a direction flag.
//   The result sink cannot stall; it must take each word when done is high.
//   Reset empties the queue, clears the direction flag and drops any pending
//   result; cell contents are left as they are and are never shown empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_queue_core_defines.svh"

module double_ended_queue_core
	import deq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  word_t       value,
	output logic        done,
	output word_t       front_value,
	output word_t       back_value,
	output logic [4:0]  count,
	output logic        is_empty,
	output logic [1:0]  status
);

	logic [CNT_W-1:0] count_q;
	logic             rev_q;
	logic             done_q;
	logic [1:0]       status_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic             put_start, put_end, take_start, take_end;
	logic             do_clear, do_reverse;
	logic             push_rejected;
	cell_ctl_t        ctl;
	word_t            cell_val [DEPTH];
	logic [IDX_W-1:0] last_idx;
	word_t            first_w, last_w;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	// Decode the action against the current direction.
	always_comb begin
		put_start  = 1'b0;
		put_end    = 1'b0;
		take_start = 1'b0;
		take_end   = 1'b0;
		do_clear   = 1'b0;
		do_reverse = 1'b0;
		case (action_t'(action))
			ACT_PUSH_FRONT: begin
				put_start = !rev_q;
				put_end   = rev_q;
			end
			ACT_PUSH_BACK: begin
				put_start = rev_q;
				put_end   = !rev_q;
			end
			ACT_POP_FRONT: begin
				take_start = !rev_q;
				take_end   = rev_q;
			end
			ACT_POP_BACK: begin
				take_start = rev_q;
				take_end   = !rev_q;
			end
			ACT_CLEAR:   do_clear   = 1'b1;
			ACT_REVERSE: do_reverse = 1'b1;
			default: ;
		endcase
	end

	// Chain control: shifts only when the action really changes the queue.
	assign ctl.shift_up   = accept && put_start && !full;
	assign ctl.shift_down = accept && take_start && !empty;

	// A push that arrives while every cell is occupied.
	assign push_rejected = accept && (put_start || put_end) && full;

	// Row of storage cells; cell 0 holds the physical first word.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t lower_w, upper_w;
		logic  append_w;

		if (i == 0) begin : g_first
			assign lower_w = value;
		end else begin : g_mid
			assign lower_w = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper_w = cell_val[i];
		end else begin : g_up
			assign upper_w = cell_val[i+1];
		end
		assign append_w = accept && put_end && !full && (count_q == CNT_W'(i));

		deq_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.append (append_w),
			.lower  (lower_w),
			.upper  (upper_w),
			.value  (value),
			.q      (cell_val[i])
		);
	end

	// Fill level, direction flag and the registered result status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rev_q    <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_DONE;
		end else begin
			done_q <= accept;
			if (accept) begin
				if ((put_start || put_end) && full) begin
					status_q <= ST_PUSH_FULL;
				end else if ((take_start || take_end) && empty) begin
					status_q <= ST_POP_EMPTY;
				end else begin
					status_q <= ST_DONE;
				end
				if (do_clear) begin
					count_q <= '0;
				end else if ((put_start || put_end) && !full) begin
					count_q <= count_q + 1'b1;
				end else if ((take_start || take_end) && !empty) begin
					count_q <= count_q - 1'b1;
				end
				if (do_reverse) begin
					rev_q <= !rev_q;
				end
			end
		end
	end

	// Result word taken from the state left by the last command.
	assign last_idx = IDX_W'(count_q - 1'b1);
	assign first_w  = cell_val[0];
	assign last_w   = cell_val[last_idx];

	assign done        = done_q;
	assign front_value = empty ? word_t'(-1) : (rev_q ? last_w : first_w);
	assign back_value  = empty ? word_t'(-1) : (rev_q ? first_w : last_w);
	assign count       = 5'(count_q);
	assign is_empty    = empty;
	assign status      = status_q;

	// Assertions.
	`DEQ_CHECK_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "fill level beyond depth")
	`DEQ_CHECK(a_result_follows, accept |=> done_q, "command gave no result word")
	`DEQ_CHECK(a_full_holds, push_rejected |=> (count_q == $past(count_q)), "rejected push moved level")
	`DEQ_CHECK(a_pop_empty, (done_q && (status_q == ST_POP_EMPTY)) |-> empty, "pop on empty with words")
	`DEQ_CHECK(a_no_double_shift, !(ctl.shift_up && ctl.shift_down), "chain shifted both ways")

endmodule
